FILE: design/scd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the serial CAN frame deframer
// Byte codes of the serial framing, field masks and the result word type.
// ----------------------------------------------------------------------------
package scd_pkg;

    // framing bytes
    localparam logic [7:0] START_BYTE = 8'hAA;
    localparam logic [7:0] END_BYTE   = 8'h55;

    // frame-info byte fields
    localparam logic [7:0] LEN_MASK = 8'h0F;
    localparam logic [7:0] EXT_FLAG = 8'h20;

    // byte counts
    localparam logic [4:0] MIN_END_COUNT = 5'd7;
    localparam logic [4:0] EXT_OVERHEAD  = 5'd7;
    localparam logic [4:0] STD_OVERHEAD  = 5'd5;
    localparam logic [4:0] COUNT_MAX     = 5'd31;

    // byte positions within a frame, start byte at position zero
    localparam int INFO_POS = 1;
    localparam int ID_POS   = 2;
    localparam int EXT_BASE = 6;
    localparam int STD_BASE = 4;

    // data slots on the result word
    localparam int DATA_SLOTS = 8;

    typedef struct packed {
        logic [31:0]                 frame_id;
        logic                        is_extended;
        logic [3:0]                  data_len;
        logic [DATA_SLOTS-1:0][7:0]  data;
    } scd_result_t;

endpackage

FILE: design/scd_frame_asm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_frame_asm: frame assembly and check
// Latches info, id and data bytes as they arrive and checks the frame on
// the end byte; flags a result in the same cycle as the closing byte.
// ----------------------------------------------------------------------------
module scd_frame_asm #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output scd_pkg::scd_result_t res
);

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [4:0] count_reg;
    logic [4:0] count_next;

    logic [7:0]  info_reg;
    logic [31:0] id_reg;
    logic [7:0]  data_reg [MAX_DATA_BYTES];

    logic       is_start;
    logic       take;
    logic [4:0] count_inc;
    logic       ext;
    logic [3:0] len;
    logic [4:0] expected;
    logic       is_end;

    // decode of the incoming word against the frame state
    always_comb
    begin
        is_start  = (rx_byte == scd_pkg::START_BYTE);
        take      = accept && !is_start && in_frame_reg;
        count_inc = (count_reg == scd_pkg::COUNT_MAX) ? count_reg : count_reg + 5'd1;
        ext       = ((info_reg & scd_pkg::EXT_FLAG) != 8'h00);
        len       = 4'(info_reg & scd_pkg::LEN_MASK);
        expected  = {1'b0, len} + (ext ? scd_pkg::EXT_OVERHEAD : scd_pkg::STD_OVERHEAD);
        is_end    = take && (rx_byte == scd_pkg::END_BYTE)
                    && (count_inc >= scd_pkg::MIN_END_COUNT);
        res_valid = is_end && (len <= 4'(MAX_DATA_BYTES)) && (count_inc == expected);
    end

    // frame state next value
    always_comb
    begin
        in_frame_next = in_frame_reg;
        count_next    = count_reg;
        if (accept && is_start)
        begin
            in_frame_next = 1'b1;
            count_next    = 5'd1;
        end
        else if (is_end)
        begin
            in_frame_next = 1'b0;
            count_next    = 5'd0;
        end
        else if (take)
        begin
            count_next = count_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            count_reg    <= 5'd0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            count_reg    <= count_next;
        end
    end

    // info and id bytes latch at their fixed positions
    always_ff @(posedge clk)
    begin
        if (take && count_reg == 5'(scd_pkg::INFO_POS))
        begin
            info_reg <= rx_byte;
        end
        for (int k = 0; k < 4; k++)
        begin
            if (take && count_reg == 5'(scd_pkg::ID_POS + k))
            begin
                id_reg[8*k +: 8] <= rx_byte;
            end
        end
    end

    // data bytes, position depends on the id size
    for (genvar j = 0; j < MAX_DATA_BYTES; j++)
    begin : g_data
        logic lane_hit;

        assign lane_hit = ext ? (count_reg == 5'(scd_pkg::EXT_BASE + j))
                              : (count_reg == 5'(scd_pkg::STD_BASE + j));

        always_ff @(posedge clk)
        begin
            if (take && lane_hit)
            begin
                data_reg[j] <= rx_byte;
            end
        end
    end

    // result word, unused id and data bytes read as zero
    assign res.frame_id    = ext ? id_reg : {16'h0000, id_reg[15:0]};
    assign res.is_extended = ext;
    assign res.data_len    = len;

    for (genvar j = 0; j < scd_pkg::DATA_SLOTS; j++)
    begin : g_out
        if (j < MAX_DATA_BYTES)
        begin : g_used
            assign res.data[j] = (4'(j) < len) ? data_reg[j] : 8'h00;
        end
        else
        begin : g_unused
            assign res.data[j] = 8'h00;
        end
    end

endmodule

FILE: design/scd_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_out_skid: output register with skid stage
// Holds the result word for the receiver and catches one more word while
// the receiver stalls, so the input side keeps running.
// ----------------------------------------------------------------------------
module scd_out_skid (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  scd_pkg::scd_result_t res,
    output logic                 full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output scd_pkg::scd_result_t out_word
);

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 skid_valid_reg;
    logic                 skid_valid_next;
    scd_pkg::scd_result_t out_reg;
    scd_pkg::scd_result_t skid_reg;
    logic                 load_out;

    // output register takes a new word when empty or when it is taken
    always_comb
    begin
        load_out        = !out_valid_reg || !out_stall;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (load_out)
        begin
            out_valid_next  = skid_valid_reg || res_valid;
            skid_valid_next = 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end
        else if (res_valid)
        begin
            skid_reg <= res;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

endmodule

FILE: design/serial_can_frame_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serial_can_frame_deframer: CAN frame recovery from a serial byte stream
// Input channel: in_valid / in_stall with rx_byte, one serial byte a word.
// Output channel: out_valid / out_stall with one decoded CAN frame a word.
// A byte 0xAA opens a frame (dropping any partial one); 0x55 closes it as
// its seventh or any later byte. Frames whose byte count does not match the
// info byte, or whose length is above MAX_DATA_BYTES, are dropped silently.
// Throughput: one byte accepted every cycle unless in_stall is high. Info,
// id and data bytes latch as they arrive, so the check on the closing byte
// needs only the byte count and the info byte. A frame is registered into
// the output buffer when its closing byte is accepted. Stall: a two-entry
// output buffer (output register plus skid stage) keeps the input running
// while one frame waits; in_stall rises only when both entries hold a frame.
// Reset: rst_n clears the frame state and the output buffer; bytes before
// the first 0xAA are ignored.
// ----------------------------------------------------------------------------
module serial_can_frame_deframer #(
    parameter int MAX_DATA_BYTES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] frame_id,
    output logic        is_extended,
    output logic [3:0]  data_len,
    output logic [7:0]  data_b0,
    output logic [7:0]  data_b1,
    output logic [7:0]  data_b2,
    output logic [7:0]  data_b3,
    output logic [7:0]  data_b4,
    output logic [7:0]  data_b5,
    output logic [7:0]  data_b6,
    output logic [7:0]  data_b7
);

    logic                 accept;
    logic                 res_valid;
    logic                 buf_full;
    scd_pkg::scd_result_t res;
    scd_pkg::scd_result_t out_word;

    // input word handshake
    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    scd_frame_asm #(
        .MAX_DATA_BYTES (MAX_DATA_BYTES)
    ) u_asm (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    scd_out_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // result word fields onto the ports
    assign frame_id    = out_word.frame_id;
    assign is_extended = out_word.is_extended;
    assign data_len    = out_word.data_len;
    assign data_b0     = out_word.data[0];
    assign data_b1     = out_word.data[1];
    assign data_b2     = out_word.data[2];
    assign data_b3     = out_word.data[3];
    assign data_b4     = out_word.data[4];
    assign data_b5     = out_word.data[5];
    assign data_b6     = out_word.data[6];
    assign data_b7     = out_word.data[7];

endmodule

FILE: design/scd_port_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scd_port_checker: port-level checks of the deframer
// Watches the top-level ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module scd_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  rx_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] frame_id,
    input logic        is_extended,
    input logic [3:0]  data_len,
    input logic [7:0]  data_b0,
    input logic [7:0]  data_b7
);

    // a stalled frame stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_id) && $stable(data_len)
            && $stable(is_extended))
        else $error("stalled output word changed");

    // standard frames carry a 16-bit id
    a_std_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_extended |-> frame_id[31:16] == 16'h0000)
        else $error("standard frame with upper id bits set");

    // length in range and unused data bytes zero
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> data_len <= 4'd8
            && (data_len != 4'd0 || data_b0 == 8'h00)
            && (data_len == 4'd8 || data_b7 == 8'h00))
        else $error("data length or unused data byte wrong");

    // a start byte never produces a frame
    a_start_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && rx_byte == scd_pkg::START_BYTE && !out_valid
            |=> !out_valid)
        else $error("frame produced by a start byte");

endmodule

bind serial_can_frame_deframer scd_port_checker u_scd_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .frame_id    (frame_id),
    .is_extended (is_extended),
    .data_len    (data_len),
    .data_b0     (data_b0),
    .data_b7     (data_b7)
);
